>>> src/ahc_pkg.sv
// Package: shared constants, payload types and exponent-table functions.
`timescale 1ns / 1ps
package ahc_pkg;

  localparam int unsigned MulTempK   = 1762;
  localparam logic [30:0] Log2eQ30   = 31'd1549082005;
  localparam int unsigned DenOfsT    = 24312;
  localparam int unsigned DenScale   = 6400;
  localparam int unsigned KelvinOfs  = 27315;
  localparam int unsigned DdScale    = 1000000;
  localparam int unsigned AhScale    = 13244704;
  localparam int unsigned YFracBits  = 24;
  localparam int unsigned NbZero     = 16;
  localparam int unsigned NbNoShift  = 80;
  localparam int unsigned QuoBits    = 30;

  typedef struct packed {
    logic [24:0]        m24;
    logic [6:0]         nb;
    logic signed [14:0] temp;
    logic [13:0]        hum;
  } mid_t;

  typedef struct packed {
    logic [15:0] abs_hum;
    logic        sat;
  } res_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bitv;
    v    = val;
    r    = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bitv > v) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (v >= r + bitv) begin
          v = v - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return r;
  endfunction

  // 2^(k/2^b) in Q30
  function automatic logic [31:0] exp2_entry(input int k, input int b);
    logic [63:0] roots [13];
    logic [63:0] acc;
    for (int i = 0; i < 13; i++) roots[i] = '0;
    roots[0] = 64'd2 << 30;
    for (int i = 1; i <= b; i++) roots[i] = isqrt64(roots[i-1] << 30);
    acc = 64'd1 << 30;
    for (int j = 0; j <= b; j++) begin
      if (((k >> j) & 1) != 0) acc = (acc * roots[b-j]) >> 30;
    end
    return acc[31:0];
  endfunction

endpackage

>>> src/ahc_fifo.sv
// Small synchronous queue used between pipeline sections and at the result side.
`timescale 1ns / 1ps
module ahc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int AW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == (AW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop) rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end
endmodule

>>> src/ahc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
`timescale 1ns / 1ps
module ahc_div_pipe #(
  parameter int NW = 57,
  parameter int DW = 28,
  parameter int QW = 30,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  localparam int CW = DW + QW;

  logic [CW-1:0] rem_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic          vld_q  [QW];

  logic [CW-1:0] rem_in  [QW];
  logic [QW-1:0] quo_in  [QW];
  logic [DW-1:0] den_in  [QW];
  logic [SW-1:0] side_in [QW];
  logic          vld_in  [QW];
  logic [CW-1:0] trial   [QW];
  logic          ge      [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem_in[k]  = CW'(num_i);
        quo_in[k]  = '0;
        den_in[k]  = den_i;
        side_in[k] = side_i;
        vld_in[k]  = valid_i;
      end else begin
        rem_in[k]  = rem_q[k-1];
        quo_in[k]  = quo_q[k-1];
        den_in[k]  = den_q[k-1];
        side_in[k] = side_q[k-1];
        vld_in[k]  = vld_q[k-1];
      end
      trial[k] = CW'(den_in[k]) << (QW - 1 - k);
      ge[k]    = rem_in[k] >= trial[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QW; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < QW; k++) vld_q[k] <= vld_in[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k]  <= ge[k] ? rem_in[k] - trial[k] : rem_in[k];
        quo_q[k]  <= {quo_in[k][QW-2:0], ge[k]};
        den_q[k]  <= den_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];
endmodule

>>> src/ahc_front.sv
// Front section: exponent y = x*log2(e) by division, then 2^frac by table and interpolation.
`timescale 1ns / 1ps
module ahc_front import ahc_pkg::*; #(
  parameter int TableBits = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [14:0] temp_i,
  input  logic [13:0]        hum_i,
  output logic               mid_push_o,
  output mid_t               mid_o,
  input  logic               mid_full_i
);
  localparam int Sh      = int'(YFracBits) - TableBits;
  localparam int TblSize = (1 << TableBits) + 1;
  localparam int SideW   = 30;

  logic [31:0] tbl [TblSize];
  for (genvar k = 0; k < TblSize; k++) begin : g_tbl
    localparam logic [31:0] Entry = exp2_entry(k, TableBits);
    assign tbl[k] = Entry;
  end

  logic adv;

  // stage 0
  logic               s0_vld_q, s0_neg_q;
  logic signed [14:0] s0_t_q;
  logic [13:0]        s0_h_q;
  logic [24:0]        s0_p_q;
  logic [27:0]        s0_den_q;
  logic [14:0]        mag;
  logic [15:0]        tsum;

  assign mag  = temp_i[14] ? 15'(~temp_i + 15'd1) : 15'(temp_i);
  assign tsum = 16'(DenOfsT) + {temp_i[14], temp_i};

  // stage 1
  logic               s1_vld_q, s1_neg_q;
  logic signed [14:0] s1_t_q;
  logic [13:0]        s1_h_q;
  logic [55:0]        s1_num_q;
  logic [27:0]        s1_den_q;

  // stage 2
  logic               s2_vld_q;
  logic [56:0]        s2_num_q;
  logic [27:0]        s2_den_q;
  logic [SideW-1:0]   s2_side_q;

  logic               dv_vld;
  logic [29:0]        dv_quo;
  logic [SideW-1:0]   dv_side;

  // exponent stages
  logic [30:0]          u;
  logic [23:0]          f;
  logic [TableBits-1:0] idx;
  logic [TableBits:0]   idx_lo, idx_hi;

  logic               e0_vld_q;
  logic [31:0]        e0_lo_q, e0_hi_q;
  logic [Sh-1:0]      e0_rem_q;
  logic [6:0]         e0_nb_q;
  logic signed [14:0] e0_t_q;
  logic [13:0]        e0_h_q;

  logic [31:0]        diff;
  logic               e1_vld_q;
  logic [31:0]        e1_lo_q;
  logic [31+Sh:0]     e1_prod_q;
  logic [6:0]         e1_nb_q;
  logic signed [14:0] e1_t_q;
  logic [13:0]        e1_h_q;

  logic [31:0] m;
  logic        e2_vld_q;
  mid_t        e2_q;

  assign adv        = !e2_vld_q || !mid_full_i;
  assign in_ready_o = adv;
  assign mid_push_o = e2_vld_q && !mid_full_i;
  assign mid_o      = e2_q;

  assign u      = dv_side[SideW-1] ? 31'(1 << 30) - 31'(dv_quo) : 31'(1 << 30) + 31'(dv_quo);
  assign f      = u[23:0];
  assign idx    = f[23:Sh];
  assign idx_lo = {1'b0, idx};
  assign idx_hi = idx_lo + 1'b1;
  assign diff   = (e0_hi_q > e0_lo_q) ? e0_hi_q - e0_lo_q : '0;
  assign m      = e1_lo_q + 32'(e1_prod_q >> Sh);

  ahc_div_pipe #(.NW(57), .DW(28), .QW(int'(QuoBits)), .SW(SideW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(s2_vld_q),
    .num_i  (s2_num_q),
    .den_i  (s2_den_q),
    .side_i (s2_side_q),
    .valid_o(dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      e0_vld_q <= 1'b0;
      e1_vld_q <= 1'b0;
      e2_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= in_valid_i;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
      e0_vld_q <= dv_vld;
      e1_vld_q <= e0_vld_q;
      e2_vld_q <= e1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_neg_q  <= temp_i[14];
      s0_t_q    <= temp_i;
      s0_h_q    <= hum_i;
      s0_p_q    <= 25'(mag) * 25'(MulTempK);
      s0_den_q  <= 28'(tsum) * 28'(DenScale);

      s1_neg_q  <= s0_neg_q;
      s1_t_q    <= s0_t_q;
      s1_h_q    <= s0_h_q;
      s1_den_q  <= s0_den_q;
      s1_num_q  <= 56'(s0_p_q) * 56'(Log2eQ30);

      s2_num_q  <= 57'(s1_num_q) + (s1_neg_q ? 57'(s1_den_q) - 57'd1 : 57'd0);
      s2_den_q  <= s1_den_q;
      s2_side_q <= {s1_neg_q, s1_t_q, s1_h_q};

      e0_lo_q   <= tbl[idx_lo];
      e0_hi_q   <= tbl[idx_hi];
      e0_rem_q  <= f[Sh-1:0];
      e0_nb_q   <= u[30:24];
      e0_t_q    <= dv_side[28:14];
      e0_h_q    <= dv_side[13:0];

      e1_lo_q   <= e0_lo_q;
      e1_prod_q <= (32+Sh)'(diff) * (32+Sh)'(e0_rem_q);
      e1_nb_q   <= e0_nb_q;
      e1_t_q    <= e0_t_q;
      e1_h_q    <= e0_h_q;

      e2_q.m24  <= m[30:6];
      e2_q.nb   <= e1_nb_q;
      e2_q.temp <= e1_t_q;
      e2_q.hum  <= e1_h_q;
    end
  end
endmodule

>>> src/ahc_back.sv
// Back section: scale by humidity and constants, divide by absolute temperature, shift, saturate.
`timescale 1ns / 1ps
module ahc_back import ahc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_pop_o,
  input  mid_t mid_i,
  output logic out_push_o,
  output res_t res_o,
  input  logic out_full_i
);
  logic adv;

  logic [15:0] tk;
  logic        b0_vld_q;
  logic [38:0] b0_p_q;
  logic [35:0] b0_dd_q;
  logic [6:0]  b0_nb_q;

  logic        b1_vld_q;
  logic [62:0] b1_big_q;
  logic [35:0] b1_dd_q;
  logic [6:0]  b1_nb_q;

  logic        dv_vld;
  logic [29:0] dv_quo;
  logic [6:0]  dv_nb;

  logic [29:0] vs;
  logic [21:0] ip;
  logic        sat;
  logic        o_vld_q;
  res_t        o_q;

  assign adv        = !o_vld_q || !out_full_i;
  assign in_pop_o   = adv && in_valid_i;
  assign out_push_o = o_vld_q && !out_full_i;
  assign res_o      = o_q;
  assign tk         = 16'(KelvinOfs) + {mid_i.temp[14], mid_i.temp};

  always_comb begin
    if (dv_nb <= 7'(NbZero)) vs = '0;
    else if (dv_nb < 7'(NbNoShift)) vs = dv_quo >> (7'(NbNoShift) - dv_nb);
    else vs = dv_quo;
  end

  assign ip  = vs[29:8];
  assign sat = ip >= 22'd255;

  ahc_div_pipe #(.NW(63), .DW(36), .QW(int'(QuoBits)), .SW(7)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(b1_vld_q),
    .num_i  (b1_big_q),
    .den_i  (b1_dd_q),
    .side_i (b1_nb_q),
    .valid_o(dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_nb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_vld_q <= 1'b0;
      b1_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else if (adv) begin
      b0_vld_q <= in_valid_i;
      b1_vld_q <= b0_vld_q;
      o_vld_q  <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b0_p_q     <= 39'(mid_i.hum) * 39'(mid_i.m24);
      b0_dd_q    <= 36'(tk) * 36'(DdScale);
      b0_nb_q    <= mid_i.nb;
      b1_big_q   <= 63'(b0_p_q) * 63'(AhScale);
      b1_dd_q    <= b0_dd_q;
      b1_nb_q    <= b0_nb_q;
      o_q.abs_hum <= {sat ? 8'hFF : ip[7:0], vs[7:0]};
      o_q.sat     <= sat;
    end
  end
endmodule

>>> src/absolute_humidity_calc.sv
// Absolute humidity calculator top level: front section, queue, back section, result queue.
// Takes one sample per cycle while full is low and returns one 8.8 g/m3 result per sample, in
// order. The path holds 71 register stages: 36 in the front, one in the queue between the
// sections, 33 in the back and one in the result queue. Most are in the two 30-stage pipelined
// restoring dividers: one for the exponent and one for the division by absolute temperature.
// A full result queue stalls the back section, and the queue between sections then stalls
// the front; full rises only once both are backed up.
`timescale 1ns / 1ps
module absolute_humidity_calc import ahc_pkg::*; #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [14:0] temp_centi_c_i,
  input  logic [13:0]        rel_hum_centi_i,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        abs_hum_q8_8_o,
  output logic               int_saturated_o
);
  logic front_ready;
  logic mid_push, mid_full, mid_empty, mid_pop;
  mid_t mid_w, mid_r;
  logic res_push, res_full;
  res_t res_w, res_r;

  assign full = !front_ready;

  ahc_front #(.TableBits(EXP_TABLE_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(push),
    .in_ready_o(front_ready),
    .temp_i    (temp_centi_c_i),
    .hum_i     (rel_hum_centi_i),
    .mid_push_o(mid_push),
    .mid_o     (mid_w),
    .mid_full_i(mid_full)
  );

  ahc_fifo #(.Width($bits(mid_t)), .Depth(4)) u_midq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .wdata_i(mid_w),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .rdata_o(mid_r),
    .empty_o(mid_empty)
  );

  ahc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(!mid_empty),
    .in_pop_o  (mid_pop),
    .mid_i     (mid_r),
    .out_push_o(res_push),
    .res_o     (res_w),
    .out_full_i(res_full)
  );

  ahc_fifo #(.Width($bits(res_t)), .Depth(2)) u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_w),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_r),
    .empty_o(empty)
  );

  assign abs_hum_q8_8_o  = res_r.abs_hum;
  assign int_saturated_o = res_r.sat;
endmodule

>>> src/ahc_checker.sv
// Port-level checker for the absolute humidity calculator, bound to the top level.
`timescale 1ns / 1ps
module ahc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic signed [14:0] temp_centi_c_i,
  input logic [13:0]        rel_hum_centi_i,
  input logic               empty,
  input logic               pop,
  input logic [15:0]        abs_hum_q8_8_o,
  input logic               int_saturated_o
);
  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (int_saturated_o == (abs_hum_q8_8_o[15:8] == 8'hFF)))
    else $error("saturation flag disagrees with high byte");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(abs_hum_q8_8_o) && $stable(int_saturated_o))
    else $error("waiting result changed");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty)
    else $error("result present right after reset");

  a_reset_not_full: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !full)
    else $error("full right after reset");
endmodule

bind absolute_humidity_calc ahc_checker u_ahc_checker (.*);
